[hw/rtl/ckbb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckbb_pkg
// Shared types, constants and register codes for the chroma key mask and
// bounding box block.
// ----------------------------------------------------------------------------
package ckbb_pkg;

    // largest frame side and the widths that follow from it
    localparam int MAX_DIM = 1024;
    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int CFG_W   = DIM_W + 1;
    localparam int CH_W    = 8;
    localparam int IDX_W   = 3;

    typedef logic [CH_W-1:0]  t_chan;
    typedef logic [DIM_W-1:0] t_coord;
    typedef logic [CFG_W-1:0] t_cfg_data;

    // register indexes of the configuration port
    typedef enum logic [IDX_W-1:0] {
        CFG_KEY_BLUE     = 3'd0,
        CFG_KEY_GREEN    = 3'd1,
        CFG_KEY_RED      = 3'd2,
        CFG_TOL_BLUE     = 3'd3,
        CFG_TOL_GREEN    = 3'd4,
        CFG_TOL_RED      = 3'd5,
        CFG_FRAME_HEIGHT = 3'd6,
        CFG_FRAME_WIDTH  = 3'd7
    } t_cfg_idx;

    // register reset values
    localparam t_chan KEY_BLUE_RST  = 8'd0;
    localparam t_chan KEY_GREEN_RST = 8'd200;
    localparam t_chan KEY_RED_RST   = 8'd50;
    localparam t_chan TOL_BLUE_RST  = 8'd90;
    localparam t_chan TOL_GREEN_RST = 8'd40;
    localparam t_chan TOL_RED_RST   = 8'd90;

    // key colour and tolerances
    typedef struct packed {
        t_chan key_blue;
        t_chan key_green;
        t_chan key_red;
        t_chan tol_blue;
        t_chan tol_green;
        t_chan tol_red;
    } t_key_cfg;

    // last column and last row index of the effective frame
    typedef struct packed {
        t_coord w_last;
        t_coord h_last;
    } t_dims;

    typedef struct packed {
        t_coord left;
        t_coord right;
        t_coord top;
        t_coord bottom;
    } t_box;

    // one result word
    typedef struct packed {
        logic  foreground;
        logic  frame_done;
        t_box  box;
    } t_res;

    // last index of a frame side, with the size clamped to 1..MAX_DIM
    function automatic t_coord last_index(input t_cfg_data v);
        t_coord r;
        if (v == '0) begin
            r = '0;
        end else if (v > CFG_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM - 1);
        end else begin
            r = DIM_W'(v - CFG_W'(1));
        end
        return r;
    endfunction

endpackage

[hw/rtl/ckbb_pix_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckbb_pix_if
// Pixel channel: valid/ready handshake with one blue, green, red word.
// ----------------------------------------------------------------------------
interface ckbb_pix_if;
    logic              valid;
    logic              ready;
    ckbb_pkg::t_chan   pix_blue;
    ckbb_pkg::t_chan   pix_green;
    ckbb_pkg::t_chan   pix_red;

    modport source (output valid, output pix_blue, output pix_green, output pix_red,
                    input ready);
    modport sink   (input valid, input pix_blue, input pix_green, input pix_red,
                    output ready);
endinterface

[hw/rtl/ckbb_res_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckbb_res_if
// Result channel: foreground bit, end of frame flag and widened box.
// ----------------------------------------------------------------------------
interface ckbb_res_if;
    logic              valid;
    logic              ready;
    logic              foreground;
    logic              frame_done;
    ckbb_pkg::t_coord  box_left;
    ckbb_pkg::t_coord  box_right;
    ckbb_pkg::t_coord  box_top;
    ckbb_pkg::t_coord  box_bottom;

    modport source (output valid, output foreground, output frame_done,
                    output box_left, output box_right, output box_top,
                    output box_bottom, input ready);
    modport sink   (input valid, input foreground, input frame_done,
                    input box_left, input box_right, input box_top,
                    input box_bottom, output ready);
endinterface

[hw/rtl/ckbb_key_match.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckbb_key_match
// Compares a pixel with the key colour; foreground unless every channel lies
// within its tolerance.
// ----------------------------------------------------------------------------
module ckbb_key_match (
    input  ckbb_pkg::t_chan    i_blue,
    input  ckbb_pkg::t_chan    i_green,
    input  ckbb_pkg::t_chan    i_red,
    input  ckbb_pkg::t_key_cfg i_key,
    output logic               o_foreground
);

    // absolute distance within tolerance
    function automatic logic near_key(input ckbb_pkg::t_chan p,
                                      input ckbb_pkg::t_chan k,
                                      input ckbb_pkg::t_chan t);
        ckbb_pkg::t_chan d;
        d = (p >= k) ? (p - k) : (k - p);
        return d <= t;
    endfunction

    // keyed out only when all three channels match
    always_comb begin
        o_foreground = !(near_key(i_blue,  i_key.key_blue,  i_key.tol_blue)  &&
                         near_key(i_green, i_key.key_green, i_key.tol_green) &&
                         near_key(i_red,   i_key.key_red,   i_key.tol_red));
    end

endmodule

[hw/rtl/ckbb_box_track.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckbb_box_track
// Raster position counters and foreground extent; builds the widened,
// clipped box on the last pixel of each frame.
// ----------------------------------------------------------------------------
module ckbb_box_track (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_foreground,
    input  logic                i_restart,
    input  ckbb_pkg::t_dims     i_dims,
    output ckbb_pkg::t_res      o_res
);

    ckbb_pkg::t_coord r_col, r_row;
    ckbb_pkg::t_coord r_min_col, r_max_col, r_min_row, r_max_row;
    logic             r_any_fg;

    ckbb_pkg::t_coord n_min_col, n_max_col, n_min_row, n_max_row;
    logic             n_any_fg;
    logic             w_row_end;
    logic             w_last;

    // extent including the current pixel
    always_comb begin
        n_min_col = (i_foreground && r_col < r_min_col) ? r_col : r_min_col;
        n_max_col = (i_foreground && r_col > r_max_col) ? r_col : r_max_col;
        n_min_row = (i_foreground && r_row < r_min_row) ? r_row : r_min_row;
        n_max_row = (i_foreground && r_row > r_max_row) ? r_row : r_max_row;
        n_any_fg  = r_any_fg | i_foreground;
        w_row_end = (r_col >= i_dims.w_last);
        w_last    = w_row_end && (r_row >= i_dims.h_last);
    end

    // result word; box widened by one and clipped when the frame held foreground
    always_comb begin
        o_res.foreground = i_foreground;
        o_res.frame_done = w_last;
        o_res.box        = '0;
        if (w_last) begin
            o_res.box.left   = n_min_col;
            o_res.box.right  = n_max_col;
            o_res.box.top    = n_min_row;
            o_res.box.bottom = n_max_row;
            if (n_any_fg) begin
                if (n_min_col != '0) begin
                    o_res.box.left = n_min_col - 1'b1;
                end
                if (n_max_col < i_dims.w_last) begin
                    o_res.box.right = n_max_col + 1'b1;
                end
                if (n_min_row != '0) begin
                    o_res.box.top = n_min_row - 1'b1;
                end
                if (n_max_row < i_dims.h_last) begin
                    o_res.box.bottom = n_max_row + 1'b1;
                end
            end
        end
    end

    // counter and extent update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_min_col <= i_dims.w_last;
            r_max_col <= '0;
            r_min_row <= i_dims.h_last;
            r_max_row <= '0;
            r_any_fg  <= 1'b0;
        end else begin
            if (i_restart || (i_step && w_last)) begin
                r_col     <= '0;
                r_row     <= '0;
                r_min_col <= i_dims.w_last;
                r_max_col <= '0;
                r_min_row <= i_dims.h_last;
                r_max_row <= '0;
                r_any_fg  <= 1'b0;
            end else if (i_step) begin
                r_min_col <= n_min_col;
                r_max_col <= n_max_col;
                r_min_row <= n_min_row;
                r_max_row <= n_max_row;
                r_any_fg  <= n_any_fg;
                if (w_row_end) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

endmodule

[hw/rtl/chroma_key_mask_bounding_box.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chroma_key_mask_bounding_box
// Chroma key mask with per-frame foreground bounding box.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock while the output side can move and gives one
// result word per pixel: the pixel is held in an input register, keyed and
// folded into the box in one pass, and the result lands in an output register.
// The output register is held while the sink stalls and the input register
// still takes a new word as long as the output side can move, so the sustained
// rate is one word per cycle. Pixels come in raster order; the block counts
// rows and columns itself. frame_done marks the last pixel of a frame and
// carries the foreground box grown by one on each side and clipped to the
// frame; on other words the box fields are zero. A frame with no foreground
// reports left = width-1, right = 0, top = height-1, bottom = 0. Writing the
// frame height or width restarts the frame. Register writes are expected only
// while no word is in flight.
// ----------------------------------------------------------------------------
module chroma_key_mask_bounding_box (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  ckbb_pkg::t_cfg_idx    i_cfg_idx,
    input  ckbb_pkg::t_cfg_data   i_cfg_data,
    ckbb_pix_if.sink              i_pix,
    ckbb_res_if.source            o_res
);

    ckbb_pkg::t_key_cfg r_key;
    ckbb_pkg::t_dims    r_dims;
    logic               r_restart;

    logic               r_s1_v;
    ckbb_pkg::t_chan    r_blue, r_green, r_red;
    logic               r_out_v;
    ckbb_pkg::t_res     r_res;

    logic               w_out_free;
    logic               w_adv;
    logic               w_acc;
    logic               w_fg;
    ckbb_pkg::t_res     w_res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key.key_blue  <= ckbb_pkg::KEY_BLUE_RST;
            r_key.key_green <= ckbb_pkg::KEY_GREEN_RST;
            r_key.key_red   <= ckbb_pkg::KEY_RED_RST;
            r_key.tol_blue  <= ckbb_pkg::TOL_BLUE_RST;
            r_key.tol_green <= ckbb_pkg::TOL_GREEN_RST;
            r_key.tol_red   <= ckbb_pkg::TOL_RED_RST;
            r_dims.w_last   <= ckbb_pkg::DIM_W'(ckbb_pkg::MAX_DIM - 1);
            r_dims.h_last   <= ckbb_pkg::DIM_W'(ckbb_pkg::MAX_DIM - 1);
            r_restart       <= 1'b0;
        end else begin
            r_restart <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ckbb_pkg::CFG_KEY_BLUE: begin
                        r_key.key_blue <= i_cfg_data[ckbb_pkg::CH_W-1:0];
                    end
                    ckbb_pkg::CFG_KEY_GREEN: begin
                        r_key.key_green <= i_cfg_data[ckbb_pkg::CH_W-1:0];
                    end
                    ckbb_pkg::CFG_KEY_RED: begin
                        r_key.key_red <= i_cfg_data[ckbb_pkg::CH_W-1:0];
                    end
                    ckbb_pkg::CFG_TOL_BLUE: begin
                        r_key.tol_blue <= i_cfg_data[ckbb_pkg::CH_W-1:0];
                    end
                    ckbb_pkg::CFG_TOL_GREEN: begin
                        r_key.tol_green <= i_cfg_data[ckbb_pkg::CH_W-1:0];
                    end
                    ckbb_pkg::CFG_TOL_RED: begin
                        r_key.tol_red <= i_cfg_data[ckbb_pkg::CH_W-1:0];
                    end
                    ckbb_pkg::CFG_FRAME_HEIGHT: begin
                        r_dims.h_last <= ckbb_pkg::last_index(i_cfg_data);
                        r_restart     <= 1'b1;
                    end
                    ckbb_pkg::CFG_FRAME_WIDTH: begin
                        r_dims.w_last <= ckbb_pkg::last_index(i_cfg_data);
                        r_restart     <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // handshake: input register moves when the output register is free
    assign w_out_free  = !r_out_v || o_res.ready;
    assign w_adv       = r_s1_v && w_out_free;
    assign i_pix.ready = !r_s1_v || w_adv;
    assign w_acc       = i_pix.valid && i_pix.ready;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_acc) begin
                r_s1_v <= 1'b1;
            end else if (w_adv) begin
                r_s1_v <= 1'b0;
            end
            if (w_adv) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // input word register
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_blue  <= i_pix.pix_blue;
            r_green <= i_pix.pix_green;
            r_red   <= i_pix.pix_red;
        end
    end

    // key compare
    ckbb_key_match u_key_match (
        .i_blue       (r_blue),
        .i_green      (r_green),
        .i_red        (r_red),
        .i_key        (r_key),
        .o_foreground (w_fg)
    );

    // position and box tracking
    ckbb_box_track u_box_track (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_adv),
        .i_foreground (w_fg),
        .i_restart    (r_restart),
        .i_dims       (r_dims),
        .o_res        (w_res)
    );

    // output word register
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_res.valid      = r_out_v;
    assign o_res.foreground = r_res.foreground;
    assign o_res.frame_done = r_res.frame_done;
    assign o_res.box_left   = r_res.box.left;
    assign o_res.box_right  = r_res.box.right;
    assign o_res.box_top    = r_res.box.top;
    assign o_res.box_bottom = r_res.box.bottom;

    // box fields are zero except on the last pixel of a frame
    a_box_zero_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.frame_done) |->
        (o_res.box_left == '0 && o_res.box_right == '0 &&
         o_res.box_top == '0 && o_res.box_bottom == '0))
        else $error("box fields set on a word that is not the end of a frame");

    // a held input word blocks new input while the output side is stalled
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && r_out_v && !o_res.ready) |-> !i_pix.ready)
        else $error("input taken while both stages are full and stalled");

    // no result straight after reset
    a_reset_empties_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid after reset");

endmodule

[sim/ckbb_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckbb_tb_pkg
// Result tracker for the chroma key mask and bounding box bench: keeps its own
// copy of the key registers, frame size, raster position and running box, and
// turns every accepted pixel word into the result word the block should give.
// ----------------------------------------------------------------------------
package ckbb_tb_pkg;

    import ckbb_pkg::*;

    class mask_box_tracker;

        // register copies
        t_chan     key_b, key_g, key_r;
        t_chan     tol_b, tol_g, tol_r;
        t_cfg_data height_reg, width_reg;

        // raster position and foreground extent of the current frame
        t_coord    col, row;
        t_coord    lo_col, hi_col, lo_row, hi_row;
        bit        seen_fg;

        // result words owed by the block, oldest first
        t_res      owed_words[$];
        int        fails;
        int        words_checked;

        function new();
            fails = 0;
            words_checked = 0;
            key_b = KEY_BLUE_RST;
            key_g = KEY_GREEN_RST;
            key_r = KEY_RED_RST;
            tol_b = TOL_BLUE_RST;
            tol_g = TOL_GREEN_RST;
            tol_r = TOL_RED_RST;
            height_reg = t_cfg_data'(MAX_DIM);
            width_reg = t_cfg_data'(MAX_DIM);
            fresh_frame();
        endfunction

        // frame side as the block uses it: 0 counts as 1, oversize as MAX_DIM
        function int eff_side(t_cfg_data v);
            if (v == '0) begin
                return 1;
            end
            if (int'(v) > MAX_DIM) begin
                return MAX_DIM;
            end
            return int'(v);
        endfunction

        function void fresh_frame();
            col = '0;
            row = '0;
            lo_col = t_coord'(eff_side(width_reg) - 1);
            hi_col = '0;
            lo_row = t_coord'(eff_side(height_reg) - 1);
            hi_row = '0;
            seen_fg = 1'b0;
        endfunction

        // register write; a new frame size restarts the frame
        function void set_reg(t_cfg_idx idx, t_cfg_data v);
            case (idx)
                CFG_KEY_BLUE: key_b = v[CH_W-1:0];
                CFG_KEY_GREEN: key_g = v[CH_W-1:0];
                CFG_KEY_RED: key_r = v[CH_W-1:0];
                CFG_TOL_BLUE: tol_b = v[CH_W-1:0];
                CFG_TOL_GREEN: tol_g = v[CH_W-1:0];
                CFG_TOL_RED: tol_r = v[CH_W-1:0];
                CFG_FRAME_HEIGHT: begin
                    height_reg = v;
                    fresh_frame();
                end
                CFG_FRAME_WIDTH: begin
                    width_reg = v;
                    fresh_frame();
                end
                default: ;
            endcase
        endfunction

        function bit close_to(t_chan p, t_chan k, t_chan t);
            int d;
            d = int'(p) - int'(k);
            if (d < 0) begin
                d = -d;
            end
            return d <= int'(t);
        endfunction

        function int pending();
            return owed_words.size();
        endfunction

        // key one accepted pixel, fold it into the box, queue its result word
        function void take_pixel(t_chan b, t_chan g, t_chan r);
            int   w, h, bl, br, bt, bb;
            bit   fg, last;
            t_res e;
            w = eff_side(width_reg);
            h = eff_side(height_reg);
            fg = !(close_to(b, key_b, tol_b) && close_to(g, key_g, tol_g) &&
                   close_to(r, key_r, tol_r));
            if (fg) begin
                if (col < lo_col) lo_col = col;
                if (col > hi_col) hi_col = col;
                if (row < lo_row) lo_row = row;
                if (row > hi_row) hi_row = row;
                seen_fg = 1'b1;
            end
            last = (int'(col) + 1 >= w) && (int'(row) + 1 >= h);
            e = '0;
            e.foreground = fg;
            e.frame_done = last;
            if (last) begin
                bl = int'(lo_col);
                br = int'(hi_col);
                bt = int'(lo_row);
                bb = int'(hi_row);
                // grow by one on each side, but only inside the frame
                if (seen_fg) begin
                    if (bt > 0) bt--;
                    if (bb + 1 < h) bb++;
                    if (bl > 0) bl--;
                    if (br + 1 < w) br++;
                end
                e.box.left = t_coord'(bl);
                e.box.right = t_coord'(br);
                e.box.top = t_coord'(bt);
                e.box.bottom = t_coord'(bb);
                fresh_frame();
            end else if (int'(col) + 1 >= w) begin
                col = '0;
                row = row + 1'b1;
            end else begin
                col = col + 1'b1;
            end
            owed_words.push_back(e);
        endfunction

        task report(string what);
            // keep the log short when the block is badly off
            if (fails < 200) begin
                $display("mismatch at word %0d: %s", words_checked, what);
            end
            fails++;
        endtask

        task compare_field(string name, int got_v, int want_v);
            if (got_v != want_v) begin
                report($sformatf("%s got %0d want %0d", name, got_v, want_v));
            end
        endtask

        // compare one accepted result word with the oldest one owed
        task check_word(t_res got);
            t_res want;
            if (owed_words.size() == 0) begin
                report("result word with no pixel outstanding");
                return;
            end
            want = owed_words.pop_front();
            compare_field("foreground", got.foreground, want.foreground);
            compare_field("frame_done", got.frame_done, want.frame_done);
            compare_field("box_left", got.box.left, want.box.left);
            compare_field("box_right", got.box.right, want.box.right);
            compare_field("box_top", got.box.top, want.box.top);
            compare_field("box_bottom", got.box.bottom, want.box.bottom);
            words_checked++;
        endtask

    endclass

endpackage

[sim/chroma_key_mask_bounding_box_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chroma_key_mask_bounding_box_tb
// Bench for the chroma key mask and bounding box block. A directed run covers
// tolerance edges, 1x1 frames, empty frames and box clipping; then random
// phases reprogram key, tolerance and frame size and stream pixels around the
// key colour, with idle and stall patterns on both channels. Every result word
// is checked against the tracker in ckbb_tb_pkg.
// ----------------------------------------------------------------------------
module chroma_key_mask_bounding_box_tb;

    import ckbb_pkg::*;
    import ckbb_tb_pkg::*;

    // longest quiet stretch of a correct run is the receiver hold-off,
    // a burst of register writes or the reset; allow plenty more
    localparam int QUIET_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 64;
    localparam int RANDOM_ITEMS = 700;
    localparam int BIG_STRETCH  = 40;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_we;
    t_cfg_idx  i_cfg_idx;
    t_cfg_data i_cfg_data;

    ckbb_pix_if pix_ch ();
    ckbb_res_if res_ch ();

    chroma_key_mask_bounding_box uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_ch),
        .o_res      (res_ch)
    );

    mask_box_tracker tracker = new();

    int        src_idle_pct;
    int        sink_idle_pct;
    int        fg_pct;
    int        rand_items;
    int        quiet_cycles;
    bit        hold_req;
    t_cfg_data next_cfg [8];
    t_res      got_word;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // accepted words on both channels, input side first
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pix_ch.valid && pix_ch.ready) begin
                tracker.take_pixel(pix_ch.pix_blue, pix_ch.pix_green, pix_ch.pix_red);
            end
            if (res_ch.valid && res_ch.ready) begin
                got_word.foreground = res_ch.foreground;
                got_word.frame_done = res_ch.frame_done;
                got_word.box.left = res_ch.box_left;
                got_word.box.right = res_ch.box_right;
                got_word.box.top = res_ch.box_top;
                got_word.box.bottom = res_ch.box_bottom;
                tracker.check_word(got_word);
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // offer one pixel word after a random gap and wait for it to be taken
    task automatic send_pixel(input t_chan b, input t_chan g, input t_chan r);
        while ($urandom_range(99) < src_idle_pct) begin
            pix_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pix_blue <= b;
        pix_ch.pix_green <= g;
        pix_ch.pix_red <= r;
        do @(posedge i_clk); while (!pix_ch.ready);
    endtask

    // stop offering and wait for every owed result word
    task automatic drain();
        pix_ch.valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    // write next_cfg for a run of register indexes, block idle
    task automatic load_regs(input t_cfg_idx first, input t_cfg_idx last);
        for (int i = int'(first); i <= int'(last); i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= t_cfg_idx'(i);
            i_cfg_data <= next_cfg[i];
            @(posedge i_clk);
            tracker.set_reg(t_cfg_idx'(i), next_cfg[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // channel value within tolerance of the key
    function automatic t_chan near_value(input t_chan k, input t_chan t);
        int lo, hi;
        lo = int'(k) - int'(t);
        hi = int'(k) + int'(t);
        if (lo < 0) lo = 0;
        if (hi > 255) hi = 255;
        return t_chan'($urandom_range(hi, lo));
    endfunction

    // channel value on or just past the tolerance edge
    function automatic t_chan edge_value(input t_chan k, input t_chan t);
        int v;
        case ($urandom_range(3))
            0: v = int'(k) - int'(t);
            1: v = int'(k) + int'(t);
            2: v = int'(k) - int'(t) - 1;
            default: v = int'(k) + int'(t) + 1;
        endcase
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return t_chan'(v);
    endfunction

    // random pixels: mostly near the key, some noise and some on the edge
    task automatic run_pixels(input int n);
        int    roll;
        t_chan b, g, r;
        repeat (n) begin
            if (rand_items < RANDOM_ITEMS / 3) begin
                src_idle_pct = 35;
                sink_idle_pct = 69;
            end else if (rand_items < 2 * RANDOM_ITEMS / 3) begin
                src_idle_pct = 69;
                sink_idle_pct = 35;
            end else begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end
            // sender pause mid frame, then a long receiver hold-off
            if (rand_items == RANDOM_ITEMS / 2) begin
                drain();
            end
            if (rand_items == 2 * RANDOM_ITEMS / 3) begin
                hold_req = 1'b1;
            end
            roll = $urandom_range(99);
            if (roll < fg_pct) begin
                b = t_chan'($urandom);
                g = t_chan'($urandom);
                r = t_chan'($urandom);
            end else if (roll < fg_pct + 10) begin
                b = edge_value(tracker.key_b, tracker.tol_b);
                g = edge_value(tracker.key_g, tracker.tol_g);
                r = edge_value(tracker.key_r, tracker.tol_r);
            end else begin
                b = near_value(tracker.key_b, tracker.tol_b);
                g = near_value(tracker.key_g, tracker.tol_g);
                r = near_value(tracker.key_r, tracker.tol_r);
            end
            send_pixel(b, g, r);
            rand_items++;
        end
    endtask

    // stimulus
    initial begin
        int kind;
        int dims;
        int n_items;
        bit frame_too;

        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_KEY_BLUE;
        i_cfg_data <= '0;
        pix_ch.valid <= 1'b0;
        pix_ch.pix_blue <= '0;
        pix_ch.pix_green <= '0;
        pix_ch.pix_red <= '0;
        src_idle_pct = 35;
        sink_idle_pct = 69;
        rand_items = 0;
        quiet_cycles = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset key and tolerances, channel by channel on and past the edge
        send_pixel(8'd0, 8'd200, 8'd50);
        send_pixel(8'd90, 8'd160, 8'd140);
        send_pixel(8'd91, 8'd200, 8'd50);
        send_pixel(8'd0, 8'd159, 8'd50);
        send_pixel(8'd0, 8'd241, 8'd50);
        send_pixel(8'd0, 8'd200, 8'd141);
        send_pixel(8'd0, 8'd240, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);

        // zero frame size acts as 1x1: every word ends a frame
        drain();
        next_cfg[CFG_FRAME_HEIGHT] = '0;
        next_cfg[CFG_FRAME_WIDTH] = '0;
        load_regs(CFG_FRAME_HEIGHT, CFG_FRAME_WIDTH);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd200, 8'd50);

        // 2x3 frames: empty one, then foreground on the last pixel only
        drain();
        next_cfg[CFG_FRAME_HEIGHT] = t_cfg_data'(2);
        next_cfg[CFG_FRAME_WIDTH] = t_cfg_data'(3);
        load_regs(CFG_FRAME_HEIGHT, CFG_FRAME_WIDTH);
        repeat (11) send_pixel(8'd0, 8'd200, 8'd50);
        send_pixel(8'd255, 8'd0, 8'd255);

        // random phases, small frames, some keep the frame running
        frame_too = 1'b1;
        while (rand_items < RANDOM_ITEMS) begin
            kind = $urandom_range(7);
            for (int c = 0; c < 3; c++) begin
                case (kind)
                    0: begin
                        next_cfg[int'(CFG_KEY_BLUE) + c] = '0;
                        next_cfg[int'(CFG_TOL_BLUE) + c] = '0;
                    end
                    1: begin
                        next_cfg[int'(CFG_KEY_BLUE) + c] = t_cfg_data'(255);
                        next_cfg[int'(CFG_TOL_BLUE) + c] = t_cfg_data'(255);
                    end
                    2: begin
                        next_cfg[int'(CFG_KEY_BLUE) + c] = t_cfg_data'($urandom_range(255));
                        next_cfg[int'(CFG_TOL_BLUE) + c] = '0;
                    end
                    3: begin
                        next_cfg[int'(CFG_KEY_BLUE) + c] = t_cfg_data'(255);
                        next_cfg[int'(CFG_TOL_BLUE) + c] = t_cfg_data'($urandom_range(60));
                    end
                    default: begin
                        next_cfg[int'(CFG_KEY_BLUE) + c] = t_cfg_data'($urandom_range(255));
                        next_cfg[int'(CFG_TOL_BLUE) + c] = t_cfg_data'($urandom_range(100));
                    end
                endcase
            end
            next_cfg[CFG_FRAME_HEIGHT] = t_cfg_data'($urandom_range(8));
            next_cfg[CFG_FRAME_WIDTH] = t_cfg_data'($urandom_range(8));
            drain();
            if (frame_too) begin
                load_regs(CFG_KEY_BLUE, CFG_FRAME_WIDTH);
            end else begin
                load_regs(CFG_KEY_BLUE, CFG_TOL_RED);
            end
            dims = tracker.eff_side(tracker.height_reg) * tracker.eff_side(tracker.width_reg);
            n_items = dims * $urandom_range(3, 1);
            if ($urandom_range(3) == 0) begin
                n_items += $urandom_range(dims - 1, 0);
            end
            fg_pct = $urandom_range(40, 2);
            run_pixels(n_items);
            frame_too = ($urandom_range(3) != 0);
        end

        // largest frame sizes: oversize width on one row, then full height on
        // one column; a short stretch of each, the first cut off by the next size write
        for (int k = 0; k < 2; k++) begin
            for (int c = 0; c < 3; c++) begin
                next_cfg[int'(CFG_KEY_BLUE) + c] = t_cfg_data'($urandom_range(255));
                next_cfg[int'(CFG_TOL_BLUE) + c] = t_cfg_data'(40);
            end
            next_cfg[CFG_FRAME_HEIGHT] = (k == 0) ? t_cfg_data'(0) : t_cfg_data'(MAX_DIM);
            next_cfg[CFG_FRAME_WIDTH] = (k == 0) ? t_cfg_data'(2047) : t_cfg_data'(1);
            drain();
            load_regs(CFG_KEY_BLUE, CFG_FRAME_WIDTH);
            fg_pct = 20;
            run_pixels(BIG_STRETCH);
        end

        // let the pipeline settle, then give the verdict
        drain();
        repeat (16) @(posedge i_clk);
        if (tracker.pending() != 0) begin
            tracker.report("result words still owed at the end");
        end
        if (tracker.fails == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
